// ===== rtl/ecsm_pkg.sv =====
// Package for the elliptic-curve scalar multiplier: widths, register indexes,
// datapath command codes and the controller/datapath status struct.
package ecsm_pkg;
    localparam int COORD_BITS  = 16;
    localparam int SCALAR_BITS = 16;
    localparam int SCNT_BITS   = $clog2(SCALAR_BITS + 1);
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CURVE_A = 1'd1;

    localparam logic [COORD_BITS-1:0] MODULUS_RST = COORD_BITS'(2029);
    localparam logic [COORD_BITS-1:0] CURVE_A_RST = COORD_BITS'(6);

    // Datapath operations, one per controller command.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // reduce inputs, a
        OP_SETUP,     // choose operands (acc+base or base+base), special cases
        OP_NUMDEN,    // form numerator and denominator
        OP_INV_INIT,
        OP_INV_STEP,  // one Euclid quotient step
        OP_LAMBDA,
        OP_X3,
        OP_Y3,
        OP_COMMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   dbl;     // operation is base = base + base
    } dp_cmd_t;

    typedef struct packed {
        logic busy;      // shared mod unit busy or current op not finished
        logic skip;      // setup or inverse found a trivial case, sum already written
        logic inv_done;  // remainder reached zero
        logic kbit;      // current scalar bit
        logic kzero;     // remaining scalar is zero
    } dp_stat_t;
endpackage

// ===== rtl/ecsm_modunit.sv =====
// Shared serial unit: quotient and remainder of a 33-bit value by a 17-bit one,
// one bit a cycle. Depends on ecsm_pkg.
module ecsm_modunit
    import ecsm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [2*COORD_BITS:0]   num,
    input  logic [COORD_BITS:0]     den,
    output logic                    busy,
    output logic [2*COORD_BITS:0]   quo,
    output logic [COORD_BITS:0]     rem
);
    localparam int NB = 2*COORD_BITS + 1;
    localparam int CB = $clog2(NB + 1);

    logic [NB-1:0]       q_reg;
    logic [COORD_BITS+1:0] r_reg;
    logic [COORD_BITS:0] d_reg;
    logic [CB-1:0]       cnt_reg;
    logic                busy_reg;
    logic [COORD_BITS+1:0] shifted;
    logic [COORD_BITS+1:0] diff;

    assign shifted = {r_reg[COORD_BITS:0], q_reg[NB-1]};
    assign diff    = shifted - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CB'(NB);
        end
        else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CB'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg) begin
            if (!diff[COORD_BITS+1]) begin
                r_reg <= diff;
                q_reg <= {q_reg[NB-2:0], 1'b1};
            end
            else begin
                r_reg <= shifted;
                q_reg <= {q_reg[NB-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quo  = q_reg;
    assign rem  = r_reg[COORD_BITS:0];
endmodule

// ===== rtl/ecsm_datapath.sv =====
// Datapath: point registers, shared serial mod unit, Euclid inverse registers.
// Depends on ecsm_pkg and ecsm_modunit.
module ecsm_datapath
    import ecsm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_cmd_t                cmd,
    input  logic [COORD_BITS-1:0]  modulus,
    input  logic [COORD_BITS-1:0]  curve_a,
    input  logic [COORD_BITS-1:0]  in_x,
    input  logic [COORD_BITS-1:0]  in_y,
    input  logic [SCALAR_BITS-1:0] in_k,
    output dp_stat_t               stat,
    output logic [COORD_BITS-1:0]  acc_x,
    output logic [COORD_BITS-1:0]  acc_y,
    output logic                   acc_inf
);
    localparam int W  = COORD_BITS;
    localparam int NB = 2*COORD_BITS + 1;

    logic [W-1:0] m_reg, a_reg, ax_reg, ay_reg, bx_reg, by_reg;
    logic         ainf_reg;
    logic [W-1:0] p1x_reg, p1y_reg, p2x_reg, p2y_reg;
    logic [W-1:0] num_reg, den_reg, lam_reg, x3_reg;
    logic [SCALAR_BITS-1:0] k_reg;
    logic         skip_reg;
    // Euclid: remainders nonnegative, t kept signed
    logic [W:0]   r0_reg, r1_reg;
    logic signed [W+1:0] t0_reg, t1_reg;
    logic [2:0]   sub_reg;  // sub-phase within an op
    logic [W-1:0] tmp_reg;

    logic         mu_start, mu_busy;
    logic [NB-1:0] mu_num, mu_quo;
    logic [W:0]   mu_den, mu_rem;

    ecsm_modunit u_mod (
        .clk(clk), .rst_n(rst_n), .start(mu_start), .num(mu_num), .den(mu_den),
        .busy(mu_busy), .quo(mu_quo), .rem(mu_rem)
    );

    logic [W-1:0] r16;
    assign r16 = mu_rem[W-1:0];

    // Multiplier into mod unit: operand pair per op
    logic [W-1:0] ma, mb;
    logic [2*W-1:0] prod_reg;
    logic [W:0]   sum1;
    logic signed [W+1:0] qt;

    always_comb begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            OP_NUMDEN: begin ma = p1x_reg; mb = p1x_reg; end
            OP_LAMBDA: begin ma = num_reg; mb = t0_reg[W-1:0]; end
            OP_X3:     begin ma = lam_reg; mb = lam_reg; end
            OP_Y3:     begin ma = lam_reg; mb = tmp_reg; end
            default:   begin ma = '0; mb = '0; end
        endcase
    end

    assign sum1 = {1'b0, p1y_reg} + {1'b0, p2y_reg};
    assign qt   = $signed({1'b0, mu_quo[W:0]});

    // Each op: set subs start the mod unit, later subs wait for mu and consume.
    always_comb begin
        mu_start = 1'b0;
        mu_num   = '0;
        mu_den   = {1'b0, m_reg};
        if (!mu_busy) begin
            case (cmd.op)
                OP_LOAD: begin
                    mu_start = (sub_reg < 3'd3);
                    mu_num = (sub_reg == 3'd0) ? NB'(in_x) :
                             (sub_reg == 3'd1) ? NB'(in_y) : NB'(curve_a);
                    mu_den = {1'b0, modulus};
                end
                OP_NUMDEN, OP_LAMBDA, OP_X3, OP_Y3: begin
                    mu_start = (sub_reg == 3'd1) || (sub_reg == 3'd3);
                    mu_num = NB'(prod_reg);
                end
                OP_INV_STEP: begin
                    mu_start = (sub_reg == 3'd0) && (r1_reg != '0);
                    mu_num = NB'(r0_reg);
                    mu_den = r1_reg;
                end
                default: mu_start = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sub_reg  <= '0;
            skip_reg <= 1'b0;
            ainf_reg <= 1'b1;
        end
        else begin
            case (cmd.op)
                OP_NONE: sub_reg <= '0;
                OP_LOAD: begin
                    if (!mu_busy) begin
                        case (sub_reg)
                            3'd1: bx_reg <= r16;
                            3'd2: by_reg <= r16;
                            3'd3: a_reg  <= r16;
                            default: begin
                                m_reg    <= modulus;
                                k_reg    <= in_k;
                                ainf_reg <= 1'b1;
                                ax_reg   <= '0;
                                ay_reg   <= '0;
                            end
                        endcase
                        if (sub_reg != 3'd4)
                            sub_reg <= sub_reg + 1'b1;
                    end
                end
                OP_SETUP: begin
                    if (sub_reg == 3'd0) begin
                        p1x_reg <= cmd.dbl ? bx_reg : ax_reg;
                        p1y_reg <= cmd.dbl ? by_reg : ay_reg;
                        p2x_reg <= bx_reg;
                        p2y_reg <= by_reg;
                        sub_reg <= 3'd1;
                        skip_reg <= 1'b0;
                    end
                    else if (sub_reg == 3'd1) begin
                        sub_reg <= 3'd2;
                        if (!cmd.dbl && ainf_reg) begin
                            // infinity plus base is base
                            ax_reg <= bx_reg; ay_reg <= by_reg; ainf_reg <= 1'b0;
                            skip_reg <= 1'b1;
                        end
                        else if (p1x_reg == p2x_reg &&
                                 (sum1 == '0 || sum1 == {1'b0, m_reg})) begin
                            skip_reg <= 1'b1;
                            if (cmd.dbl) k_reg <= '0;
                            else ainf_reg <= 1'b1;
                        end
                    end
                    else
                        sub_reg <= '0;
                end
                OP_NUMDEN: begin
                    if (!mu_busy) begin
                        case (sub_reg)
                            3'd0: begin prod_reg <= ma * mb; sub_reg <= 3'd1; end
                            3'd1: sub_reg <= 3'd2;
                            3'd2: begin
                                if (p1x_reg == p2x_reg && p1y_reg == p2y_reg) begin
                                    prod_reg <= (2*W)'(3 * r16) + (2*W)'(a_reg);
                                    tmp_reg <= (2*W)'(2 * p1y_reg) >= (2*W)'(m_reg) ?
                                        W'((W+1)'(2 * p1y_reg) - (W+1)'(m_reg)) :
                                        W'(2 * p1y_reg);
                                end
                                else begin
                                    prod_reg <= (2*W)'(p2y_reg >= p1y_reg ?
                                        p2y_reg - p1y_reg : p2y_reg + m_reg - p1y_reg);
                                    tmp_reg <= p2x_reg >= p1x_reg ?
                                        p2x_reg - p1x_reg : W'(p2x_reg + m_reg - p1x_reg);
                                end
                                sub_reg <= 3'd3;
                            end
                            3'd3: sub_reg <= 3'd4;
                            3'd4: begin num_reg <= r16; sub_reg <= 3'd5; end
                            default: sub_reg <= '0;
                        endcase
                    end
                end
                OP_INV_INIT: begin
                    r0_reg <= {1'b0, m_reg};
                    r1_reg <= {1'b0, tmp_reg};
                    t0_reg <= '0;
                    t1_reg <= (W+2)'(1);
                    sub_reg <= '0;
                end
                OP_INV_STEP: begin
                    if (!mu_busy) begin
                        case (sub_reg)
                            3'd0: begin
                                if (r1_reg != '0)
                                    sub_reg <= 3'd1;
                                else begin
                                    // gcd above one: no inverse, the sum is infinity
                                    if (r0_reg > (W+1)'(1)) begin
                                        skip_reg <= 1'b1;
                                        if (cmd.dbl) k_reg <= '0;
                                        else ainf_reg <= 1'b1;
                                    end
                                    if (t0_reg < 0)
                                        t0_reg <= t0_reg + $signed({2'b00, m_reg});
                                    sub_reg <= 3'd4;
                                end
                            end
                            3'd1: sub_reg <= 3'd2;
                            3'd2: begin
                                prod_reg <= (2*W)'(qt * t1_reg);
                                sub_reg <= 3'd3;
                            end
                            3'd3: begin
                                t0_reg <= t1_reg;
                                t1_reg <= t0_reg - (W+2)'($signed(prod_reg[W+1:0]));
                                r0_reg <= r1_reg;
                                r1_reg <= mu_rem;
                                sub_reg <= 3'd0;
                            end
                            default: sub_reg <= '0;
                        endcase
                    end
                end
                OP_LAMBDA, OP_X3, OP_Y3: begin
                    if (!mu_busy) begin
                        case (sub_reg)
                            3'd0: begin prod_reg <= ma * mb; sub_reg <= 3'd1; end
                            3'd1: sub_reg <= 3'd2;
                            3'd2: begin
                                if (cmd.op == OP_LAMBDA) lam_reg <= r16;
                                else if (cmd.op == OP_X3) begin
                                    // (l^2 + 2m - x1 - x2) mod m, values < 3m
                                    prod_reg <= (2*W)'(r16) + (2*W)'(2*m_reg)
                                        - (2*W)'(p1x_reg) - (2*W)'(p2x_reg);
                                end
                                else
                                    prod_reg <= (2*W)'(r16) + (2*W)'(m_reg)
                                        - (2*W)'(p1y_reg);
                                sub_reg <= (cmd.op == OP_LAMBDA) ? 3'd5 : 3'd3;
                            end
                            3'd3: sub_reg <= 3'd4;
                            3'd4: begin
                                if (cmd.op == OP_X3) begin
                                    x3_reg <= r16;
                                    tmp_reg <= p1x_reg >= r16 ? p1x_reg - r16 :
                                        W'(p1x_reg + m_reg - r16);
                                end
                                else tmp_reg <= r16;
                                sub_reg <= 3'd5;
                            end
                            default: sub_reg <= '0;
                        endcase
                    end
                end
                OP_COMMIT: begin
                    if (cmd.dbl) begin
                        if (!skip_reg) begin bx_reg <= x3_reg; by_reg <= tmp_reg; end
                        k_reg <= k_reg >> 1;
                    end
                    else if (!skip_reg) begin
                        ax_reg <= x3_reg; ay_reg <= tmp_reg; ainf_reg <= 1'b0;
                    end
                    sub_reg <= '0;
                end
                default: sub_reg <= '0;
            endcase
        end
    end

    // A failed inversion or doubling to infinity leaves infinity in the target.
    // Base at infinity: the remaining scalar is cleared so the loop ends.
    assign stat.busy = mu_busy || mu_start ||
        (cmd.op == OP_LOAD && sub_reg != 3'd4) ||
        (cmd.op == OP_SETUP && sub_reg != 3'd2) ||
        ((cmd.op == OP_NUMDEN || cmd.op == OP_LAMBDA || cmd.op == OP_X3 ||
          cmd.op == OP_Y3) && sub_reg != 3'd5) ||
        (cmd.op == OP_INV_STEP && sub_reg != 3'd4);
    assign stat.skip     = skip_reg;
    assign stat.inv_done = (r1_reg == '0);
    assign stat.kbit     = k_reg[0];
    assign stat.kzero    = (k_reg == '0);
    assign acc_x   = ax_reg;
    assign acc_y   = ay_reg;
    assign acc_inf = ainf_reg;
endmodule

// ===== rtl/ecsm_ctrl.sv =====
// Controller: sequences load, per-bit add and double, and result handoff.
// Depends on ecsm_pkg.
module ecsm_ctrl
    import ecsm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     trivial,   // inf input, zero scalar or modulus below three
    input  dp_stat_t stat,
    input  logic     out_free,
    output dp_cmd_t  cmd,
    output logic     idle,
    output logic     done,
    output logic     force_inf
);
    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_CHECK, S_SETUP, S_NUMDEN, S_INV_INIT, S_INV,
        S_LAMBDA, S_X3, S_Y3, S_COMMIT, S_DONE
    } state_t;

    state_t state_reg;
    logic   dbl_reg, inf_reg;
    logic [SCNT_BITS-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            dbl_reg   <= 1'b0;
            inf_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else begin
            case (state_reg)
                S_IDLE: if (start) begin
                    inf_reg   <= trivial;
                    state_reg <= trivial ? S_DONE : S_LOAD;
                    cnt_reg   <= SCNT_BITS'(SCALAR_BITS);
                end
                S_LOAD: if (!stat.busy) state_reg <= S_CHECK;
                S_CHECK: begin
                    if (stat.kzero || cnt_reg == '0) state_reg <= S_DONE;
                    else begin
                        dbl_reg   <= !stat.kbit;
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP: if (!stat.busy)
                    state_reg <= stat.skip ? S_COMMIT : S_NUMDEN;
                S_NUMDEN:   if (!stat.busy) state_reg <= S_INV_INIT;
                S_INV_INIT: state_reg <= S_INV;
                S_INV: if (!stat.busy)
                    state_reg <= stat.skip ? S_COMMIT : S_LAMBDA;
                S_LAMBDA: if (!stat.busy) state_reg <= S_X3;
                S_X3:     if (!stat.busy) state_reg <= S_Y3;
                S_Y3:     if (!stat.busy) state_reg <= S_COMMIT;
                S_COMMIT: begin
                    if (dbl_reg) begin
                        cnt_reg   <= cnt_reg - 1'b1;
                        state_reg <= S_CHECK;
                    end
                    else begin
                        dbl_reg   <= 1'b1;
                        state_reg <= S_SETUP;
                    end
                end
                S_DONE: if (out_free) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd.dbl = dbl_reg;
        case (state_reg)
            S_LOAD:     cmd.op = OP_LOAD;
            S_SETUP:    cmd.op = OP_SETUP;
            S_NUMDEN:   cmd.op = OP_NUMDEN;
            S_INV_INIT: cmd.op = OP_INV_INIT;
            S_INV:      cmd.op = OP_INV_STEP;
            S_LAMBDA:   cmd.op = OP_LAMBDA;
            S_X3:       cmd.op = OP_X3;
            S_Y3:       cmd.op = OP_Y3;
            S_COMMIT:   cmd.op = OP_COMMIT;
            default:    cmd.op = OP_NONE;
        endcase
    end

    assign idle      = (state_reg == S_IDLE);
    assign done      = (state_reg == S_DONE) && out_free;
    assign force_inf = inf_reg;
endmodule

// ===== rtl/ec_scalar_multiply_prime_field.sv =====
// Elliptic-curve scalar multiplier, right-to-left double-and-add over GF(p).
// Loads with three reductions in the serial mod unit, then per scalar bit runs a check
// step, a point double and for a set bit a point add; each point op runs a chain of
// reductions and Euclid inverse steps through the shared serial mod unit.
// Zero scalar, infinity point or modulus below 3 go straight to the result.
// One request at a time. Reset (rst_n, async low): modulus 2029, a = 6, no output.
module ec_scalar_multiply_prime_field
    import ecsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // point_x, point_y, point_inf, scalar, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result_x, result_y, result_inf, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [15:0] cfg_data
);
    logic [COORD_BITS-1:0] modulus_reg, curve_a_reg;
    logic [COORD_BITS-1:0] in_x_reg, in_y_reg;
    logic [SCALAR_BITS-1:0] in_k_reg;
    logic [COORD_BITS-1:0] ax, ay;
    logic ainf, idle, done, force_inf, start, out_free;
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic m_tvalid_reg;
    logic [39:0] m_tdata_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            modulus_reg <= MODULUS_RST;
            curve_a_reg <= CURVE_A_RST;
        end
        else if (cfg_valid) begin
            if (cfg_index == REG_MODULUS) modulus_reg <= cfg_data;
            else if (cfg_index == REG_CURVE_A) curve_a_reg <= cfg_data;
        end
    end

    assign s_tready = idle;
    assign start    = s_tvalid && idle;
    assign out_free = !m_tvalid_reg || m_tready;

    // request fields held for the whole computation
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_x_reg <= '0;
            in_y_reg <= '0;
            in_k_reg <= '0;
        end
        else if (start) begin
            in_x_reg <= s_tdata[15:0];
            in_y_reg <= s_tdata[31:16];
            in_k_reg <= s_tdata[48:33];
        end
    end

    ecsm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start),
        .trivial(s_tdata[32] || modulus_reg < COORD_BITS'(3) || s_tdata[48:33] == '0),
        .stat(stat), .out_free(out_free), .cmd(cmd), .idle(idle), .done(done),
        .force_inf(force_inf)
    );

    ecsm_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .modulus(modulus_reg),
        .curve_a(curve_a_reg), .in_x(in_x_reg), .in_y(in_y_reg),
        .in_k(in_k_reg), .stat(stat), .acc_x(ax), .acc_y(ay), .acc_inf(ainf)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) m_tvalid_reg <= 1'b0;
        else if (done) m_tvalid_reg <= 1'b1;
        else if (m_tready) m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk) begin
        if (done) begin
            if (force_inf || ainf) m_tdata_reg <= {7'd0, 1'b1, 32'd0};
            else m_tdata_reg <= {7'd0, 1'b0, ay, ax};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !idle |-> !s_tready) else $error("input taken while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> idle) else $error("controller did not return to idle");
endmodule
